/* rtl/hbt_pkg.sv */
// ----------------------------------------------------------------------------
// hbt_pkg: shared types and constants of the hash bucket table
// Transfer payloads, operation and status codes, sequencer states and the
// default table geometry.
// ----------------------------------------------------------------------------
package hbt_pkg;

   // Default geometry
   localparam int NUM_BUCKETS_DEF  = 10;
   localparam int BUCKET_DEPTH_DEF = 8;

   // Field widths
   localparam int KEY_W    = 32;
   localparam int BUCKET_W = 4;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_FOUND     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BUCKET_W-1:0] bucket;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_QN,
      S_READ,
      S_UPDATE
   } state_type;

endpackage

/* rtl/hbt_ram.sv */
// ----------------------------------------------------------------------------
// hbt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/hash_bucket_table.sv */
// ----------------------------------------------------------------------------
// hash_bucket_table: fixed-slot hash set with insert and search
// Buckets are chosen by key modulo NUM_BUCKETS; each bucket holds up to
// BUCKET_DEPTH keys kept in one wide RAM row next to a fill-count RAM.
// ----------------------------------------------------------------------------
// Each request (insert or search of a 32-bit key) yields exactly one response
// carrying a status and the bucket index (low 4 bits). One request is handled
// at a time, in these steps: acceptance, which multiplies the key by a
// reciprocal of the bucket count; scaling the estimated quotient back by the
// bucket count; reducing the remainder and addressing the bucket RAMs; and the
// registered RAM read, the parallel compare of all slots and the write-back.
// The response is loaded in that last step, and only after it can the next
// request be taken, so the block never takes a new request before it is
// through with the last. The response sits in an output register, so the next
// request is taken while it waits; that request then holds before its RAM
// read until the register is free. After reset the fill counts are cleared by
// a pass over all NUM_BUCKETS buckets, one bucket per cycle, during which
// req_stall is high. Inserts into a full bucket are dropped and report full;
// duplicate keys are stored.
// ----------------------------------------------------------------------------
module hash_bucket_table #(
   parameter int NUM_BUCKETS  = hbt_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = hbt_pkg::BUCKET_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hbt_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hbt_pkg::rsp_type rsp_data
);

   localparam int KEY_W   = hbt_pkg::KEY_W;
   localparam int BKT_W   = $clog2(NUM_BUCKETS);
   localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
   localparam int ROW_W   = BUCKET_DEPTH * KEY_W;
   localparam int SHIFT   = KEY_W - 1 + BKT_W;
   localparam int REM_W   = BKT_W + 2;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / NUM_BUCKETS;
   localparam logic [KEY_W-1:0] RECIP = RECIP_WIDE[KEY_W-1:0];
   localparam logic [REM_W-1:0] NB_REM = REM_W'(NUM_BUCKETS);
   localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NUM_BUCKETS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUCKET_DEPTH);

   hbt_pkg::state_type state_ff, state_in;

   logic                   accept;
   logic                   out_free;
   logic [BKT_W-1:0]       clr_ptr_ff, clr_ptr_in;
   hbt_pkg::opcode_type    op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [2*KEY_W-1:0]     prod_ff;
   logic [KEY_W-1:0]       quot;
   logic [KEY_W-1:0]       qn_ff;
   logic [REM_W-1:0]       rem0, rem1, rem2;
   logic [BKT_W-1:0]       bkt_ff;
   logic                   rsp_valid_ff;
   hbt_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   key_wr_en;
   logic [ROW_W-1:0]       key_rd_row, key_wr_row;
   logic                   cnt_wr_en;
   logic [BKT_W-1:0]       cnt_wr_addr;
   logic [CNT_W-1:0]       cnt_wr_data, cnt_rd;
   logic [BUCKET_DEPTH-1:0] hit;
   logic                   full;

   // Handshake
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbt_pkg::S_CLEAR:  if (clr_ptr_ff == LAST_BKT) state_in = hbt_pkg::S_IDLE;
         hbt_pkg::S_IDLE:   if (req_valid) state_in = hbt_pkg::S_QN;
         hbt_pkg::S_QN:     state_in = hbt_pkg::S_READ;
         hbt_pkg::S_READ:   if (out_free) state_in = hbt_pkg::S_UPDATE;
         hbt_pkg::S_UPDATE: state_in = hbt_pkg::S_IDLE;
         default:           state_in = hbt_pkg::S_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      case (state_ff)
         hbt_pkg::S_IDLE: req_stall = 1'b0;
         default:         req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hbt_pkg::S_CLEAR;
         clr_ptr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   // Advance the clear pointer during the reset pass
   assign clr_ptr_in = (state_ff == hbt_pkg::S_CLEAR) ? clr_ptr_ff + 1'b1 : clr_ptr_ff;

   // Capture the request and form key times reciprocal
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_data.opcode;
         key_ff  <= req_data.key;
         prod_ff <= req_data.key * RECIP;
      end
   end

   // Estimated quotient times bucket count
   assign quot = KEY_W'(prod_ff >> SHIFT);

   always_ff @(posedge clock) begin
      if (state_ff == hbt_pkg::S_QN) begin
         qn_ff <= quot * KEY_W'(NUM_BUCKETS);
      end
   end

   // Remainder falls below three bucket counts; correct twice
   assign rem0 = REM_W'(key_ff - qn_ff);
   assign rem1 = (rem0 >= NB_REM) ? rem0 - NB_REM : rem0;
   assign rem2 = (rem1 >= NB_REM) ? rem1 - NB_REM : rem1;

   // Hold the bucket for the write-back
   always_ff @(posedge clock) begin
      if (state_ff == hbt_pkg::S_READ) begin
         bkt_ff <= rem2[BKT_W-1:0];
      end
   end

   // Compare the key against all filled slots
   always_comb begin
      for (int s = 0; s < BUCKET_DEPTH; s++) begin
         hit[s] = (CNT_W'(s) < cnt_rd) &&
                  (key_rd_row[s*KEY_W +: KEY_W] == key_ff);
      end
   end

   assign full = (cnt_rd >= FULL_CNT);

   // Place the key in the next free slot of the row
   always_comb begin
      for (int s = 0; s < BUCKET_DEPTH; s++) begin
         key_wr_row[s*KEY_W +: KEY_W] = (CNT_W'(s) == cnt_rd) ?
                                        key_ff : key_rd_row[s*KEY_W +: KEY_W];
      end
   end

   // Write back on a successful insert; clear counts after reset
   assign key_wr_en   = (state_ff == hbt_pkg::S_UPDATE) &&
                        (op_ff == hbt_pkg::OP_INSERT) && !full;
   assign cnt_wr_en   = key_wr_en || (state_ff == hbt_pkg::S_CLEAR);
   assign cnt_wr_addr = (state_ff == hbt_pkg::S_CLEAR) ? clr_ptr_ff : bkt_ff;
   assign cnt_wr_data = (state_ff == hbt_pkg::S_CLEAR) ? '0 : cnt_rd + 1'b1;

   hbt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_BUCKETS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (bkt_ff),
      .wr_data (key_wr_row),
      .rd_addr (rem2[BKT_W-1:0]),
      .rd_data (key_rd_row)
   );

   hbt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BUCKETS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (rem2[BKT_W-1:0]),
      .rd_data (cnt_rd)
   );

   // Build the response
   always_comb begin
      rsp_in.bucket = hbt_pkg::BUCKET_W'(bkt_ff);
      if (op_ff == hbt_pkg::OP_INSERT) begin
         rsp_in.status = full ? hbt_pkg::STATUS_FULL : hbt_pkg::STATUS_INSERTED;
      end else begin
         rsp_in.status = (|hit) ? hbt_pkg::STATUS_FOUND : hbt_pkg::STATUS_NOT_FOUND;
      end
   end

   // Output register: load on update, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == hbt_pkg::S_UPDATE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == hbt_pkg::S_UPDATE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
